/* src/att_pkg.sv */
// Shared types, constants and the arctangent table for the tilt angle block.
package att_pkg;

   // Axis value after the divide by eight.
   localparam int AX_W = 13;
   // CORDIC vector and angle widths (angles in degrees * 2^24).
   localparam int VEC_W = 34;
   localparam int ANG_W = 34;
   localparam int ITERS = 28;
   localparam int SCALE_SHIFT = 16;
   localparam int FRAC_SHIFT = 16;
   localparam int K_SHIFT = 30;
   // CORDIC gain, held with 30 fraction bits.
   localparam logic [30:0] K_Q30 = 31'd1768195389;
   localparam logic signed [ANG_W-1:0] DEG180 = 34'sd3019898880;
   localparam int ROLL_LIM = 46080;
   localparam int PITCH_LIM = 23040;

   typedef struct packed {
      logic signed [15:0] x_word;
      logic signed [15:0] y_word;
      logic signed [15:0] z_word;
   } req_beat_type;

   typedef struct packed {
      logic signed [16:0] roll_angle;
      logic signed [15:0] pitch_angle;
   } rsp_beat_type;

   // atan(2^-i) in degrees * 2^24.
   function automatic logic signed [ANG_W-1:0] atan_step(input int idx);
      logic signed [ANG_W-1:0] v;
      unique case (idx)
         0: v = 34'sd754974720;
         1: v = 34'sd445687608;
         2: v = 34'sd235489084;
         3: v = 34'sd119537938;
         4: v = 34'sd60000937;
         5: v = 34'sd30029719;
         6: v = 34'sd15018523;
         7: v = 34'sd7509720;
         8: v = 34'sd3754917;
         9: v = 34'sd1877466;
         10: v = 34'sd938734;
         11: v = 34'sd469367;
         12: v = 34'sd234684;
         13: v = 34'sd117342;
         14: v = 34'sd58671;
         15: v = 34'sd29335;
         16: v = 34'sd14668;
         17: v = 34'sd7334;
         18: v = 34'sd3667;
         19: v = 34'sd1833;
         20: v = 34'sd917;
         21: v = 34'sd458;
         22: v = 34'sd229;
         23: v = 34'sd115;
         24: v = 34'sd57;
         25: v = 34'sd29;
         26: v = 34'sd14;
         27: v = 34'sd7;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

/* src/att_front.sv */
// Input stage: registers a sample beat and divides each axis by eight.
module att_front import att_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   enable,
   input  logic                   in_valid,
   input  req_beat_type           in_beat,
   output logic                   out_valid,
   output logic signed [AX_W-1:0] out_x,
   output logic signed [AX_W-1:0] out_y,
   output logic signed [AX_W-1:0] out_z
);

   logic                   valid_ff;
   logic signed [AX_W-1:0] x_ff, y_ff, z_ff;
   logic signed [AX_W-1:0] x_in, y_in, z_in;

   // Divide by eight, truncating toward zero.
   function automatic logic signed [AX_W-1:0] div8(input logic signed [15:0] w);
      logic signed [16:0] adj;
      adj = 17'(w) + (w[15] ? 17'sd7 : 17'sd0);
      return adj[15:3];
   endfunction

   assign x_in = div8(in_beat.x_word);
   assign y_in = div8(in_beat.y_word);
   assign z_in = div8(in_beat.z_word);

   // Valid clears at reset; the axis values need none.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_x = x_ff;
   assign out_y = y_ff;
   assign out_z = z_ff;

endmodule

/* src/att_cordic.sv */
// Pipelined vectoring CORDIC: atan2 and scaled magnitude, one stage per step.
module att_cordic import att_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    enable,
   input  logic                    in_valid,
   input  logic signed [VEC_W-1:0] in_y,
   input  logic signed [VEC_W-1:0] in_x,
   input  logic signed [ANG_W-1:0] in_side,
   output logic                    out_valid,
   output logic signed [ANG_W-1:0] out_angle,
   output logic signed [VEC_W-1:0] out_mag,
   output logic signed [ANG_W-1:0] out_side
);

   logic                    valid_ff [0:ITERS];
   logic                    zero_ff  [0:ITERS];
   logic signed [VEC_W-1:0] x_ff     [0:ITERS];
   logic signed [VEC_W-1:0] y_ff     [0:ITERS];
   logic signed [ANG_W-1:0] a_ff     [0:ITERS];
   logic signed [ANG_W-1:0] side_ff  [0:ITERS];

   // Fold stage: a vector in the left half plane is turned by 180 degrees.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (enable) begin
         valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         zero_ff[0] <= (in_x == '0) && (in_y == '0);
         side_ff[0] <= in_side;
         if (in_x < 0) begin
            x_ff[0] <= -in_x;
            y_ff[0] <= -in_y;
            a_ff[0] <= (in_y >= 0) ? DEG180 : -DEG180;
         end else begin
            x_ff[0] <= in_x;
            y_ff[0] <= in_y;
            a_ff[0] <= '0;
         end
      end
   end

   // Rotation stages: each drives y toward zero by one table angle.
   for (genvar i = 0; i < ITERS; i++) begin : g_step
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i+1] <= 1'b0;
         end else if (enable) begin
            valid_ff[i+1] <= valid_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            zero_ff[i+1] <= zero_ff[i];
            side_ff[i+1] <= side_ff[i];
            if (y_ff[i] > 0) begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               a_ff[i+1] <= a_ff[i] + atan_step(i);
            end else begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               a_ff[i+1] <= a_ff[i] - atan_step(i);
            end
         end
      end
   end

   assign out_valid = valid_ff[ITERS];
   assign out_angle = zero_ff[ITERS] ? '0 : a_ff[ITERS];
   assign out_mag = x_ff[ITERS];
   assign out_side = side_ff[ITERS];

endmodule

/* src/accel_tilt_angles_core.sv */
// Top level of the tilt angle block: roll and pitch from one accelerometer sample.
//
// One request beat carries the three raw axis words (x, y, z). Each is divided
// by eight, then roll = atan2(y, z) runs through a vectoring CORDIC.
// Its magnitude output, sqrt(y*y + z*z) times the CORDIC gain, feeds a second
// CORDIC with -x scaled by the same gain, which gives pitch. Both angles leave
// on the response beat in units of 1/256 degree, rounded and saturated.
//
// Throughput: one beat per cycle while no response is held. An accepted beat
// passes through the input stage, two 29-stage CORDICs, the gain multiply and
// the output register on its way to the response beat.
// The whole pipeline moves as one; when the receiver holds rsp_ready low with
// a response waiting, every stage holds and req_ready drops, so nothing is
// lost or repeated. Synchronous reset empties the pipeline by clearing the
// valid bits; no state survives between samples.
module accel_tilt_angles_core import att_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_beat_type req_beat,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_beat_type rsp_beat
);

   localparam int PROD_W = VEC_W + K_SHIFT - SCALE_SHIFT;

   logic                    advance;
   logic                    fr_valid;
   logic signed [AX_W-1:0]  fr_x, fr_y, fr_z;
   logic signed [VEC_W-1:0] roll_yv, roll_xv;
   logic signed [ANG_W-1:0] roll_side;
   logic                    rc_valid;
   logic signed [ANG_W-1:0] rc_angle, rc_side;
   logic signed [VEC_W-1:0] rc_mag;
   logic                    mul_valid_ff;
   logic signed [VEC_W-1:0] mul_y_ff, mul_y_in, mul_x_ff;
   logic signed [ANG_W-1:0] mul_roll_ff;
   logic signed [PROD_W-1:0] prod;
   logic                    pc_valid;
   logic signed [ANG_W-1:0] pc_angle, pc_side;
   logic signed [VEC_W-1:0] pc_mag;
   logic                    rsp_valid_ff;
   rsp_beat_type            rsp_beat_ff, rsp_beat_in;

   // The pipeline holds only while a finished beat waits at the output.
   assign advance = !(rsp_valid_ff && !rsp_ready);
   assign req_ready = advance;

   att_front u_front (
      .clock     (clock),
      .reset     (reset),
      .enable    (advance),
      .in_valid  (req_valid),
      .in_beat   (req_beat),
      .out_valid (fr_valid),
      .out_x     (fr_x),
      .out_y     (fr_y),
      .out_z     (fr_z)
   );

   // Roll vector is (z, y) with 16 fraction bits; x rides along for pitch.
   assign roll_yv = VEC_W'(fr_y) <<< SCALE_SHIFT;
   assign roll_xv = VEC_W'(fr_z) <<< SCALE_SHIFT;
   assign roll_side = ANG_W'(fr_x);

   att_cordic u_roll (
      .clock     (clock),
      .reset     (reset),
      .enable    (advance),
      .in_valid  (fr_valid),
      .in_y      (roll_yv),
      .in_x      (roll_xv),
      .in_side   (roll_side),
      .out_valid (rc_valid),
      .out_angle (rc_angle),
      .out_mag   (rc_mag),
      .out_side  (rc_side)
   );

   // Scale -x by the CORDIC gain so it matches the magnitude from the roll pass.
   assign prod = (-PROD_W'(rc_side)) * PROD_W'($signed({1'b0, K_Q30}));
   assign mul_y_in = prod[PROD_W-1:K_SHIFT-SCALE_SHIFT];

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
      end else if (advance) begin
         mul_valid_ff <= rc_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mul_y_ff <= mul_y_in;
         mul_x_ff <= rc_mag;
         mul_roll_ff <= rc_angle;
      end
   end

   att_cordic u_pitch (
      .clock     (clock),
      .reset     (reset),
      .enable    (advance),
      .in_valid  (mul_valid_ff),
      .in_y      (mul_y_ff),
      .in_x      (mul_x_ff),
      .in_side   (mul_roll_ff),
      .out_valid (pc_valid),
      .out_angle (pc_angle),
      .out_mag   (pc_mag),
      .out_side  (pc_side)
   );

   // Round to 1/256 degree, halves up, and saturate to the given bound.
   function automatic logic signed [17:0] to_units(input logic signed [ANG_W-1:0] a,
                                                   input int lim);
      logic signed [ANG_W-1:0] s;
      logic signed [17:0]      u;
      s = a + (ANG_W'(1) <<< (FRAC_SHIFT - 1));
      u = 18'(s >>> FRAC_SHIFT);
      if (u > 18'(lim)) begin
         u = 18'(lim);
      end else if (u < -18'(lim)) begin
         u = -18'(lim);
      end
      return u;
   endfunction

   always_comb begin
      logic signed [17:0] r;
      logic signed [17:0] p;
      r = to_units(pc_side, ROLL_LIM);
      p = to_units(pc_angle, PITCH_LIM);
      rsp_beat_in.roll_angle = r[16:0];
      rsp_beat_in.pitch_angle = p[15:0];
   end

   // Output register; the magnitude of the pitch pass is not needed.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= pc_valid && (pc_mag == pc_mag);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_beat_ff <= rsp_beat_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_beat = rsp_beat_ff;

endmodule

/* tb/tb.sv */
// Self-checking testbench for the tilt angle block: directed table, then random samples.
`timescale 1ns / 1ps

module tb;
   import att_pkg::*;

   localparam int NUM_RANDOM = 950;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 120;
   localparam int ATAN_STEPS = 28;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   req_beat_type req_beat;
   logic         rsp_valid;
   logic         rsp_ready;
   rsp_beat_type rsp_beat;

   accel_tilt_angles_core DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_beat(req_beat),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_beat(rsp_beat)
   );

   // One row of the directed part; known marks an answer typed in by hand.
   typedef struct {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
      bit                 known;
      int                 roll;
      int                 pitch;
   } tilt_row_type;

   longint       atan_deg[ATAN_STEPS];
   rsp_beat_type angle_queue[$];
   bit           row_known;
   rsp_beat_type row_typed;
   int           fail_count;
   int           cycle_count;
   bit           quiet_phase;

   // Clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Arctangent of 1/n in radians * 2^48 by its power series.
   function automatic longint unsigned atan_of_inv(longint unsigned n);
      longint unsigned term;
      longint unsigned sum;
      longint unsigned nn;
      longint unsigned k;
      term = (64'd1 << 48) / n;
      sum = term;
      nn = n * n;
      k = 1;
      forever begin
         term = term / nn;
         if (term == 0) break;
         if (k[0]) sum = sum - term / (2 * k + 1);
         else sum = sum + term / (2 * k + 1);
         k++;
      end
      return sum;
   endfunction

   // Angle table in degrees * 2^24, pi from Machin's formula.
   function automatic void fill_atan_table();
      longint unsigned pi_q;
      longint unsigned q;
      longint unsigned a;
      pi_q = 4 * (4 * atan_of_inv(5) - atan_of_inv(239));
      q = pi_q >> 24;
      atan_deg[0] = longint'(45) <<< 24;
      for (int i = 1; i < ATAN_STEPS; i++) begin
         a = atan_of_inv(64'd1 << i);
         atan_deg[i] = longint'((a * 180 + q / 2) / q);
      end
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   // Vectoring CORDIC: atan2(yy, xx) in degrees * 2^24.
   function automatic longint vector_angle(longint yy, longint xx);
      longint base;
      longint acc;
      longint dx;
      longint dy;
      base = 0;
      acc = 0;
      if (xx == 0 && yy == 0) return 0;
      if (xx < 0) begin
         base = (yy >= 0) ? (longint'(180) <<< 24) : -(longint'(180) <<< 24);
         xx = -xx;
         yy = -yy;
      end
      for (int i = 0; i < ATAN_STEPS; i++) begin
         dx = yy >>> i;
         dy = xx >>> i;
         if (yy > 0) begin
            xx = xx + dx;
            yy = yy - dy;
            acc = acc + atan_deg[i];
         end else begin
            xx = xx - dx;
            yy = yy + dy;
            acc = acc - atan_deg[i];
         end
      end
      return base + acc;
   endfunction

   function automatic longint round_clamp(longint a, longint lim);
      longint u;
      u = (a + (longint'(1) <<< 15)) >>> 16;
      if (u > lim) u = lim;
      if (u < -lim) u = -lim;
      return u;
   endfunction

   function automatic rsp_beat_type predict_tilt(req_beat_type b);
      rsp_beat_type r;
      longint ax;
      longint ay;
      longint az;
      longint unsigned m2;
      longint mag;
      ax = longint'(b.x_word) / 8;
      ay = longint'(b.y_word) / 8;
      az = longint'(b.z_word) / 8;
      r.roll_angle = 17'(round_clamp(vector_angle(ay * 65536, az * 65536), ROLL_LIM));
      m2 = longint'(ay * ay + az * az);
      mag = longint'(int_sqrt(m2 << 32));
      r.pitch_angle = 16'(round_clamp(vector_angle(-ax * 65536, mag), PITCH_LIM));
      return r;
   endfunction

   // Angles carry a tolerance of one unit.
   function automatic bit angle_close(int want, int got);
      return (want - got <= 1) && (got - want <= 1);
   endfunction

   // Directed table.
   tilt_row_type tilt_rows[] = '{
      '{16'sh0000, 16'sh0000, 16'sh0000, 1, 0, 0},
      '{16'sh0007, -16'sh0007, 16'sh0007, 1, 0, 0},
      '{-16'sh8000, 16'sh0000, 16'sh0000, 1, 0, 23040},
      '{16'sh7fff, 16'sh0000, 16'sh0000, 1, 0, -23040},
      '{16'sh0000, 16'sh0000, -16'sh0008, 1, 46080, 0},
      '{16'sh0000, 16'sh0000, -16'sh8000, 1, 46080, 0},
      '{16'sh0000, 16'sh0000, 16'sh7fff, 1, 0, 0},
      '{16'sh0000, 16'sh0008, 16'sh0000, 1, 23040, 0},
      '{16'sh0000, -16'sh8000, 16'sh0000, 1, -23040, 0},
      '{16'sh0000, 16'sh7fff, 16'sh0000, 1, 23040, 0},
      '{16'sh0008, 16'sh0000, 16'sh0000, 1, 0, -23040},
      '{-16'sh0008, 16'sh0000, 16'sh0000, 1, 0, 23040},
      '{16'sh7fff, 16'sh7fff, 16'sh7fff, 0, 0, 0},
      '{-16'sh8000, -16'sh8000, -16'sh8000, 0, 0, 0},
      '{16'sh7fff, -16'sh8000, 16'sh7fff, 0, 0, 0},
      '{-16'sh8000, 16'sh7fff, -16'sh8000, 0, 0, 0},
      '{16'sh1000, 16'sh1000, 16'sh1000, 0, 0, 0},
      '{16'sh0000, 16'sh0008, -16'sh0008, 0, 0, 0},
      '{16'sh0000, -16'sh0008, -16'sh0008, 0, 0, 0},
      '{-16'sh000f, 16'sh000f, 16'sh0010, 0, 0, 0},
      '{16'sh4000, -16'sh2000, 16'sh0008, 0, 0, 0},
      '{-16'sh5555, 16'sh2aaa, -16'sh1234, 0, 0, 0}
   };

   // Cycle counter and timeout.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d angles outstanding", $realtime, angle_queue.size());
         $display("accel_tilt_angles_core: mismatch");
         $finish;
      end
   end

   // Record the expected angles for every accepted sample beat: the typed answer
   // where the row has one, the predictor otherwise.
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         angle_queue.push_back(row_known ? row_typed : predict_tilt(req_beat));
      end
   end

   // Compare every accepted result beat with the oldest prediction.
   always @(posedge clock) begin
      rsp_beat_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (angle_queue.size() == 0) begin
            $display("%0t: unexpected result beat roll %0d pitch %0d", $realtime,
                     rsp_beat.roll_angle, rsp_beat.pitch_angle);
            fail_count++;
         end else begin
            want = angle_queue.pop_front();
            if (!angle_close(want.roll_angle, rsp_beat.roll_angle)) begin
               $display("%0t: roll expected %0d actual %0d", $realtime,
                        want.roll_angle, rsp_beat.roll_angle);
               fail_count++;
            end
            if (!angle_close(want.pitch_angle, rsp_beat.pitch_angle)) begin
               $display("%0t: pitch expected %0d actual %0d", $realtime,
                        want.pitch_angle, rsp_beat.pitch_angle);
               fail_count++;
            end
         end
      end
   end

   // Receiver stalls in random bursts until the quiet phase.
   initial begin
      rsp_ready = 1'b0;
      @(posedge clock iff !reset);
      forever begin
         if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 20)) @(posedge clock);
      end
   end

   // Send one sample beat, with an optional idle burst ahead of it.
   task automatic send_sample(req_beat_type b);
      if (!quiet_phase && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_beat <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   function automatic logic [15:0] random_word();
      case ($urandom_range(0, 5))
         0: return 16'($urandom_range(0, 15)) - 16'd8;
         1: return 16'($urandom_range(0, 511)) - 16'd256;
         2: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
         3: return 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   // Stimulus.
   initial begin
      req_beat_type b;
      rsp_beat_type typed;
      rsp_beat_type hand;
      fail_count = 0;
      cycle_count = 0;
      quiet_phase = 1'b0;
      row_known = 1'b0;
      row_typed = '0;
      req_valid = 1'b0;
      req_beat = '0;
      reset = 1'b1;
      fill_atan_table();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (tilt_rows[i]) begin
         b.x_word = tilt_rows[i].x;
         b.y_word = tilt_rows[i].y;
         b.z_word = tilt_rows[i].z;
         hand.roll_angle = 17'(tilt_rows[i].roll);
         hand.pitch_angle = 16'(tilt_rows[i].pitch);
         // Hand-typed answers are checked against the predictor's own view.
         if (tilt_rows[i].known) begin
            typed = predict_tilt(b);
            if (!angle_close(tilt_rows[i].roll, typed.roll_angle) ||
                !angle_close(tilt_rows[i].pitch, typed.pitch_angle)) begin
               $display("%0t: row %0d expected %0d/%0d actual %0d/%0d", $realtime, i,
                        tilt_rows[i].roll, tilt_rows[i].pitch,
                        typed.roll_angle, typed.pitch_angle);
               fail_count++;
            end
         end
         row_known <= tilt_rows[i].known;
         row_typed <= hand;
         send_sample(b);
      end
      row_known <= 1'b0;

      for (int n = 0; n < NUM_RANDOM; n++) begin
         // Hold off once until every result is back.
         if (n == NUM_RANDOM / 2) begin
            req_valid <= 1'b0;
            @(posedge clock);
            while (angle_queue.size() != 0) @(posedge clock);
         end
         if (n == NUM_RANDOM - 150) quiet_phase = 1'b1;
         b.x_word = random_word();
         b.y_word = random_word();
         b.z_word = random_word();
         send_sample(b);
      end
      req_valid <= 1'b0;

      while (angle_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("accel_tilt_angles_core: match");
      end else begin
         $display("accel_tilt_angles_core: mismatch");
      end
      $finish;
   end

endmodule
